// File: rtl/msgp_pkg.sv
// shared constants, types and codes for the msgpack subset tokenizer
`default_nettype none
package msgp_pkg;

   // stack sizing
   localparam int MAX_DEPTH = 16;
   localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);
   localparam int COUNT_W   = 33;
   localparam int NEST_W    = 5;
   localparam int KIND_W    = 3;
   localparam int ERR_W     = 2;

   // type byte boundaries
   localparam logic [7:0] B_POSFIX_MAX = 8'h7f;
   localparam logic [7:0] B_NEGFIX_MIN = 8'he0;
   localparam logic [7:0] B_FALSE      = 8'hc2;
   localparam logic [7:0] B_TRUE       = 8'hc3;
   localparam logic [7:0] B_UINT_FIRST = 8'hcc;
   localparam logic [7:0] B_INT_LAST   = 8'hd3;
   localparam logic [7:0] B_STR8       = 8'hd9;
   localparam logic [7:0] B_STR32      = 8'hdb;
   localparam logic [7:0] B_FIXSTR     = 8'ha0;
   localparam logic [7:0] B_FIXSTR_LEN = 8'h1f;
   localparam logic [7:0] B_FIXMAP     = 8'h80;
   localparam logic [7:0] B_FIXARR     = 8'h90;
   localparam logic [7:0] B_FIX_CNT    = 8'h0f;
   localparam logic [7:0] B_MAP16      = 8'hde;
   localparam logic [7:0] B_MAP32      = 8'hdf;
   localparam logic [7:0] B_ARR16      = 8'hdc;
   localparam logic [7:0] B_ARR32      = 8'hdd;

   // token kinds
   localparam logic [KIND_W-1:0] K_INT  = 3'd0;
   localparam logic [KIND_W-1:0] K_BOOL = 3'd1;
   localparam logic [KIND_W-1:0] K_STRH = 3'd2;
   localparam logic [KIND_W-1:0] K_STRB = 3'd3;
   localparam logic [KIND_W-1:0] K_MAP  = 3'd4;
   localparam logic [KIND_W-1:0] K_ARR  = 3'd5;
   localparam logic [KIND_W-1:0] K_ERR  = 3'd6;

   // error codes
   localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] E_UNKNOWN = 2'd1;
   localparam logic [ERR_W-1:0] E_EARLY   = 2'd2;
   localparam logic [ERR_W-1:0] E_DEPTH   = 2'd3;

   // control into one stack cell
   typedef struct packed {
      logic               push;
      logic               dec;
      logic [COUNT_W-1:0] count;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: rtl/msgp_cell.sv
// one level of the container stack: remaining item count and close chain
`default_nettype none
module msgp_cell (
   input  logic                  clock,
   input  msgp_pkg::cell_ctl_type ctl,
   output logic                  pop
);
   import msgp_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               is_one;

   // last item of this level closes it and passes the count-off below
   assign is_one = (count_ff == COUNT_W'(1));
   assign pop    = ctl.dec & is_one;

   // load on open, count down on a finished item
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = ctl.count;
      end else if (ctl.dec && !is_one) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

endmodule
`default_nettype wire

// File: rtl/msgpack_subset_tokenizer.sv
// msgpack subset tokenizer top level: byte decode, stack of cells, output register
// a token appears on rsp, registered, in the cycle after the byte that causes it
// throughput: one byte per cycle while rsp is not stalled; the count-off through
// the cell row closes any number of finished containers within that same cycle
// reset: synchronous, clears phase, level, decoder registers and output valid;
// stack counts are loaded when a container opens and need no clearing
`default_nettype none
module msgpack_subset_tokenizer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_byte_in,
   input  logic                        req_end_of_message,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [msgp_pkg::KIND_W-1:0] rsp_token_kind,
   output logic [63:0]                 rsp_token_value,
   output logic                        rsp_value_unsigned,
   output logic [msgp_pkg::NEST_W-1:0] rsp_nest_depth,
   output logic [msgp_pkg::ERR_W-1:0]  rsp_error_code,
   output logic                        rsp_object_done
);
   import msgp_pkg::*;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_DONE    = 3'd3;
   localparam logic [2:0] PH_ABORT   = 3'd4;

   logic [2:0]         phase_ff, phase_in, ph_mid, ph_fin;
   logic [7:0]         type_ff, type_in;
   logic [3:0]         hdr_ff, hdr_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        pay_ff, pay_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in, lvl_c;

   logic               fire;
   logic [7:0]         c;
   logic               cmp_req, push, emit, emit_fin;
   logic [COUNT_W-1:0] push_count;
   logic [KIND_W-1:0]  kind, kind_fin;
   logic [63:0]        val, val_fin;
   logic               uns, uns_fin, done_fin, chain_done;
   logic [ERR_W-1:0]   err, err_fin;
   logic [NEST_W-1:0]  depth_fin;
   logic               open_req, open_map, strh_req;
   logic [31:0]        open_count, strh_len;
   logic [2:0]         int_code;

   logic [MAX_DEPTH:0]   popv;
   logic [MAX_DEPTH-1:0] pop_lo;
   logic [MAX_DEPTH-1:0] boundary;
   cell_ctl_type         ctl [MAX_DEPTH];

   logic                 rsp_valid_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [63:0]          value_ff;
   logic                 uns_ff, done_ff;
   logic [NEST_W-1:0]    depth_ff;
   logic [ERR_W-1:0]     err_ff;

   assign fire      = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign c         = req_byte_in;
   assign int_code  = 3'(type_ff - B_UINT_FIRST);

   // decode of one byte against the current phase
   always_comb begin
      ph_mid     = phase_ff;
      type_in    = type_ff;
      hdr_in     = hdr_ff;
      acc_in     = acc_ff;
      pay_in     = pay_ff;
      cmp_req    = 1'b0;
      push       = 1'b0;
      push_count = '0;
      emit       = 1'b0;
      kind       = K_INT;
      val        = '0;
      uns        = 1'b0;
      err        = E_NONE;
      open_req   = 1'b0;
      open_map   = 1'b0;
      open_count = '0;
      strh_req   = 1'b0;
      strh_len   = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (c <= B_POSFIX_MAX) begin
               emit = 1'b1; cmp_req = 1'b1; val = {56'd0, c}; uns = 1'b1;
            end else if (c >= B_NEGFIX_MIN) begin
               emit = 1'b1; cmp_req = 1'b1; val = {56'hff_ffff_ffff_ffff, c};
            end else if (c == B_FALSE || c == B_TRUE) begin
               emit = 1'b1; cmp_req = 1'b1; kind = K_BOOL;
               val = {63'd0, c == B_TRUE};
            end else if (c >= B_UINT_FIRST && c <= B_INT_LAST) begin
               type_in = c; acc_in = '0; ph_mid = PH_HEADER;
               hdr_in  = 4'(4'd1 << 2'(c - B_UINT_FIRST));
            end else if (c >= B_FIXSTR && c <= (B_FIXSTR | B_FIXSTR_LEN)) begin
               strh_req = 1'b1; strh_len = {27'd0, 5'(c & B_FIXSTR_LEN)};
            end else if (c >= B_STR8 && c <= B_STR32) begin
               type_in = c; acc_in = '0; ph_mid = PH_HEADER;
               hdr_in  = 4'(4'd1 << 2'(c - B_STR8));
            end else if (c >= B_FIXMAP && c <= (B_FIXMAP | B_FIX_CNT)) begin
               open_req = 1'b1; open_map = 1'b1; open_count = {28'd0, c[3:0]};
            end else if (c == B_MAP16 || c == B_MAP32) begin
               type_in = c; acc_in = '0; ph_mid = PH_HEADER;
               hdr_in  = (c == B_MAP16) ? 4'd2 : 4'd4;
            end else if (c >= B_FIXARR && c <= (B_FIXARR | B_FIX_CNT)) begin
               open_req = 1'b1; open_count = {28'd0, c[3:0]};
            end else if (c == B_ARR16 || c == B_ARR32) begin
               type_in = c; acc_in = '0; ph_mid = PH_HEADER;
               hdr_in  = (c == B_ARR16) ? 4'd2 : 4'd4;
            end else begin
               emit = 1'b1; kind = K_ERR; err = E_UNKNOWN; ph_mid = PH_ABORT;
            end
         end
         PH_HEADER: begin
            acc_in = {acc_ff[55:0], c};
            hdr_in = hdr_ff - 4'd1;
            if (hdr_ff == 4'd1) begin
               if (type_ff >= B_UINT_FIRST && type_ff <= B_INT_LAST) begin
                  emit = 1'b1; cmp_req = 1'b1; uns = ~int_code[2];
                  case (int_code[1:0])
                     2'd0: val = {{56{acc_in[7] & int_code[2]}}, acc_in[7:0]};
                     2'd1: val = {{48{acc_in[15] & int_code[2]}}, acc_in[15:0]};
                     2'd2: val = {{32{acc_in[31] & int_code[2]}}, acc_in[31:0]};
                     default: val = acc_in;
                  endcase
               end else if (type_ff >= B_STR8 && type_ff <= B_STR32) begin
                  strh_req = 1'b1; strh_len = acc_in[31:0];
               end else if (type_ff == B_MAP16 || type_ff == B_MAP32) begin
                  open_req = 1'b1; open_map = 1'b1; open_count = acc_in[31:0];
               end else begin
                  open_req = 1'b1; open_count = acc_in[31:0];
               end
            end
         end
         PH_PAYLOAD: begin
            pay_in  = pay_ff - 32'd1;
            emit    = 1'b1;
            kind    = K_STRB;
            val     = {56'd0, c};
            cmp_req = (pay_ff == 32'd1);
         end
         default: begin
         end
      endcase

      // string header: empty string is a finished item
      if (strh_req) begin
         emit = 1'b1; kind = K_STRH; val = {32'd0, strh_len};
         if (strh_len == '0) begin
            cmp_req = 1'b1;
         end else begin
            pay_in = strh_len; ph_mid = PH_PAYLOAD;
         end
      end

      // container header: empty one is a finished item, else open a level
      if (open_req) begin
         emit = 1'b1;
         kind = open_map ? K_MAP : K_ARR;
         if (open_count == '0) begin
            cmp_req = 1'b1;
         end else if (lvl_ff >= LEVEL_W'(MAX_DEPTH)) begin
            kind = K_ERR; err = E_DEPTH; ph_mid = PH_ABORT;
         end else begin
            val        = {32'd0, open_count};
            push       = 1'b1;
            push_count = open_map ? {open_count, 1'b0} : {1'b0, open_count};
            ph_mid     = PH_IDLE;
         end
      end
   end

   // row of stack cells; the count-off runs from the top level downward
   assign popv[MAX_DEPTH] = 1'b0;
   assign pop_lo          = {popv[MAX_DEPTH-2:0], 1'b0};

   genvar gi;
   generate
      for (gi = 0; gi < MAX_DEPTH; gi++) begin : g_cell
         assign ctl[gi].push  = fire & push & (lvl_ff == LEVEL_W'(gi));
         assign ctl[gi].count = push_count;
         assign ctl[gi].dec   = (fire & cmp_req & (lvl_ff == LEVEL_W'(gi + 1)))
                                | popv[gi + 1];
         assign boundary[gi]  = popv[gi] & ~pop_lo[gi];
         msgp_cell u_cell (
            .clock (clock),
            .ctl   (ctl[gi]),
            .pop   (popv[gi])
         );
      end
   endgenerate

   // level after closing finished containers
   always_comb begin
      lvl_c = lvl_ff;
      if (cmp_req) begin
         for (int i = 0; i < MAX_DEPTH; i++) begin
            if (boundary[i]) begin
               lvl_c = LEVEL_W'(i);
            end
         end
      end
   end

   assign chain_done = (lvl_ff == '0) | popv[0];

   // finish: completion, end of message and rearm
   always_comb begin
      ph_fin    = ph_mid;
      emit_fin  = emit;
      kind_fin  = kind;
      val_fin   = val;
      uns_fin   = uns;
      err_fin   = err;
      done_fin  = cmp_req & chain_done;
      depth_fin = NEST_W'(lvl_c);
      lvl_in    = push ? (lvl_ff + LEVEL_W'(1)) : lvl_c;
      phase_in  = ph_mid;
      if (cmp_req) begin
         ph_fin = chain_done ? PH_DONE : PH_IDLE;
      end
      phase_in = ph_fin;
      if (req_end_of_message) begin
         if (ph_fin == PH_IDLE || ph_fin == PH_HEADER || ph_fin == PH_PAYLOAD) begin
            emit_fin  = 1'b1;
            kind_fin  = K_ERR;
            val_fin   = '0;
            uns_fin   = 1'b0;
            err_fin   = E_EARLY;
            done_fin  = 1'b0;
            depth_fin = NEST_W'(lvl_in);
         end
         phase_in = PH_IDLE;
         lvl_in   = '0;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         lvl_ff   <= '0;
         type_ff  <= '0;
         hdr_ff   <= '0;
         acc_ff   <= '0;
         pay_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         lvl_ff   <= lvl_in;
         if (req_end_of_message) begin
            type_ff <= '0;
            hdr_ff  <= '0;
            acc_ff  <= '0;
            pay_ff  <= '0;
         end else begin
            type_ff <= type_in;
            hdr_ff  <= hdr_in;
            acc_ff  <= acc_in;
            pay_ff  <= pay_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit_fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit_fin) begin
         kind_ff  <= kind_fin;
         value_ff <= val_fin;
         uns_ff   <= uns_fin;
         depth_ff <= depth_fin;
         err_ff   <= err_fin;
         done_ff  <= done_fin;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_token_kind     = kind_ff;
   assign rsp_token_value    = value_ff;
   assign rsp_value_unsigned = uns_ff;
   assign rsp_nest_depth     = depth_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_object_done    = done_ff;

   // checks
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LEVEL_W'(MAX_DEPTH))
      else $error("stack level above maximum depth");

   a_eom_rearm: assert property (@(posedge clock) disable iff (reset)
      fire && req_end_of_message |=> phase_ff == PH_IDLE && lvl_ff == '0)
      else $error("block not rearmed after end of message");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      fire && emit_fin && done_fin |=> lvl_ff == '0)
      else $error("object done with containers still open");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((kind_ff == K_ERR) == (err_ff != E_NONE)))
      else $error("error code and token kind disagree");

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      fire && emit_fin && kind_fin == K_ERR |=> phase_ff == PH_ABORT
      || phase_ff == PH_IDLE)
      else $error("error token did not abort the message");

endmodule
`default_nettype wire

// File: tb/msgpack_subset_tokenizer_tb.sv
// msgpack subset tokenizer testbench: directed table, nesting depth, random messages
`default_nettype none
module msgpack_subset_tokenizer_tb;
   import msgp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_BYTES   = 1760;

   // parser phases of the predictor
   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_PAYLOAD, PH_DONE, PH_ABORT
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [63:0]       value;
      logic              uns;
      logic [NEST_W-1:0] depth;
      logic [ERR_W-1:0]  err;
      logic              done;
   } token_type;

   // one row of the directed table
   typedef struct {
      logic [7:0] b;
      logic       eom;
      logic       typed;
      token_type  tok;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_byte_in = '0;
   logic req_end_of_message = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_token_kind;
   logic [63:0] rsp_token_value;
   logic rsp_value_unsigned;
   logic [NEST_W-1:0] rsp_nest_depth;
   logic [ERR_W-1:0] rsp_error_code;
   logic rsp_object_done;

   msgpack_subset_tokenizer dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   phase_type   ph;
   logic [7:0]  tbyte;
   int unsigned hdr_left;
   logic [63:0] acc;
   logic [31:0] pay_left;
   logic [32:0] items_left [MAX_DEPTH];
   int unsigned level;

   token_type tokens_due [$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;

   function automatic token_type make_tok(logic [KIND_W-1:0] k, logic [63:0] v, logic u,
                                          logic [ERR_W-1:0] e, logic d);
      token_type t;
      t.kind = k; t.value = v; t.uns = u; t.depth = level[NEST_W-1:0];
      t.err = e; t.done = d;
      return t;
   endfunction

   function automatic void clear_parser();
      ph = PH_IDLE; tbyte = '0; hdr_left = 0; acc = '0; pay_left = '0; level = 0;
   endfunction

   // count off one finished item, closing full containers
   function automatic logic count_off_item();
      logic [32:0] v;
      forever begin
         if (level == 0) begin
            ph = PH_DONE;
            return 1'b1;
         end
         v = items_left[level-1] - 33'd1;
         items_left[level-1] = v;
         if (v != 0) begin
            ph = PH_IDLE;
            return 1'b0;
         end
         level--;
      end
   endfunction

   function automatic token_type open_container(logic [KIND_W-1:0] k, logic [63:0] cnt);
      logic d;
      token_type t;
      if (cnt == 0) begin
         d = count_off_item();
         return make_tok(k, 64'd0, 1'b0, E_NONE, d);
      end
      if (level >= MAX_DEPTH) begin
         ph = PH_ABORT;
         return make_tok(K_ERR, 64'd0, 1'b0, E_DEPTH, 1'b0);
      end
      t = make_tok(k, cnt, 1'b0, E_NONE, 1'b0);
      items_left[level] = (k == K_MAP) ? {cnt[31:0], 1'b0} : {1'b0, cnt[31:0]};
      level++;
      ph = PH_IDLE;
      return t;
   endfunction

   function automatic token_type string_head(logic [63:0] len);
      logic d;
      if (len == 0) begin
         d = count_off_item();
         return make_tok(K_STRH, 64'd0, 1'b0, E_NONE, d);
      end
      pay_left = len[31:0];
      ph = PH_PAYLOAD;
      return make_tok(K_STRH, len, 1'b0, E_NONE, 1'b0);
   endfunction

   function automatic void begin_header(logic [7:0] c, int unsigned n);
      tbyte = c; hdr_left = n; acc = '0; ph = PH_HEADER;
   endfunction

   // predicts the token for one byte; returns 1 if a token is produced
   function automatic logic tokenize_byte(logic [7:0] c, logic eom, output token_type t);
      logic got, d, u;
      int unsigned code, bits;
      logic [63:0] v;
      got = 1'b0;
      case (ph)
         PH_IDLE: begin
            got = 1'b1;
            if (c <= B_POSFIX_MAX) begin
               d = count_off_item(); t = make_tok(K_INT, {56'd0, c}, 1'b1, E_NONE, d);
            end else if (c >= B_NEGFIX_MIN) begin
               d = count_off_item(); t = make_tok(K_INT, {{56{1'b1}}, c}, 1'b0, E_NONE, d);
            end else if (c == B_FALSE || c == B_TRUE) begin
               d = count_off_item();
               t = make_tok(K_BOOL, {63'd0, c == B_TRUE}, 1'b0, E_NONE, d);
            end else if (c >= B_UINT_FIRST && c <= B_INT_LAST) begin
               begin_header(c, 1 << ((c - B_UINT_FIRST) & 3)); got = 1'b0;
            end else if (c >= B_FIXSTR && c <= B_FIXSTR + B_FIXSTR_LEN) begin
               t = string_head({56'd0, c & B_FIXSTR_LEN});
            end else if (c >= B_STR8 && c <= B_STR32) begin
               begin_header(c, 1 << (c - B_STR8)); got = 1'b0;
            end else if (c >= B_FIXMAP && c <= B_FIXMAP + B_FIX_CNT) begin
               t = open_container(K_MAP, {56'd0, c & B_FIX_CNT});
            end else if (c == B_MAP16 || c == B_MAP32) begin
               begin_header(c, 2 << (c - B_MAP16)); got = 1'b0;
            end else if (c >= B_FIXARR && c <= B_FIXARR + B_FIX_CNT) begin
               t = open_container(K_ARR, {56'd0, c & B_FIX_CNT});
            end else if (c == B_ARR16 || c == B_ARR32) begin
               begin_header(c, 2 << (c - B_ARR16)); got = 1'b0;
            end else begin
               ph = PH_ABORT; t = make_tok(K_ERR, 64'd0, 1'b0, E_UNKNOWN, 1'b0);
            end
         end
         PH_HEADER: begin
            acc = {acc[55:0], c};
            hdr_left--;
            if (hdr_left == 0) begin
               got = 1'b1;
               v = acc;
               if (tbyte >= B_UINT_FIRST && tbyte <= B_INT_LAST) begin
                  code = tbyte - B_UINT_FIRST;
                  bits = 8 << (code & 3);
                  u = code < 4;
                  if (!u && bits < 64 && v[bits-1]) v = v | ({64{1'b1}} << bits);
                  d = count_off_item();
                  t = make_tok(K_INT, v, u, E_NONE, d);
               end else if (tbyte >= B_STR8 && tbyte <= B_STR32) begin
                  t = string_head(v);
               end else if (tbyte == B_MAP16 || tbyte == B_MAP32) begin
                  t = open_container(K_MAP, v);
               end else begin
                  t = open_container(K_ARR, v);
               end
            end
         end
         PH_PAYLOAD: begin
            got = 1'b1;
            d = 1'b0;
            pay_left--;
            if (pay_left == 0) d = count_off_item();
            t = make_tok(K_STRB, {56'd0, c}, 1'b0, E_NONE, d);
         end
         default: ;
      endcase
      if (eom) begin
         if (ph == PH_IDLE || ph == PH_HEADER || ph == PH_PAYLOAD) begin
            t = make_tok(K_ERR, 64'd0, 1'b0, E_EARLY, 1'b0);
            got = 1'b1;
         end
         clear_parser();
      end
      return got;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // response checking and watchdog
   always @(posedge clock) begin
      token_type w;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               report_mismatch("unexpected token kind", 64'(rsp_token_kind), 64'd0);
            end else begin
               w = tokens_due.pop_front();
               if (rsp_token_kind != w.kind)
                  report_mismatch("kind", 64'(rsp_token_kind), 64'(w.kind));
               if (rsp_token_value != w.value)
                  report_mismatch("value", rsp_token_value, w.value);
               if (rsp_value_unsigned != w.uns)
                  report_mismatch("unsigned", 64'(rsp_value_unsigned), 64'(w.uns));
               if (rsp_nest_depth != w.depth)
                  report_mismatch("depth", 64'(rsp_nest_depth), 64'(w.depth));
               if (rsp_error_code != w.err)
                  report_mismatch("error", 64'(rsp_error_code), 64'(w.err));
               if (rsp_object_done != w.done)
                  report_mismatch("done", 64'(rsp_object_done), 64'(w.done));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver stall pattern: calm and busy stretches
   initial begin
      int mode;
      forever begin
         @(negedge clock);
         mode = (int'($time) / 2000) % 3;
         if (mode == 0) rsp_stall <= 1'b0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   int unsigned burst_left = 0;

   // send one byte; the transaction completes at the edge where stall is low
   task automatic send_byte(logic [7:0] b, logic eom, logic typed, token_type tok);
      token_type t;
      int gap;
      logic got_tok;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_end_of_message <= eom;
      got_tok = tokenize_byte(b, eom, t);
      if (typed && (!got_tok || t != tok))
         report_mismatch("table row", t.value, tok.value);
      if (got_tok) tokens_due = {tokens_due, t};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // random well-formed object builder, into a byte queue
   logic [7:0] msg [$];

   function automatic void add_byte(logic [7:0] b);
      msg = {msg, b};
   endfunction

   task automatic push_be(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) add_byte(v[i*8 +: 8]);
   endtask

   task automatic build_object(int depth);
      int sel, n, kind_sel;
      logic is_map;
      logic [63:0] r;
      sel = $urandom_range(0, 9);
      r = {$urandom, $urandom};
      if (depth >= 18) sel = $urandom_range(0, 2);
      case (sel)
         0: add_byte(8'($urandom_range(0, 255)) & 8'h7f
                     | (($urandom_range(0, 1)) ? 8'he0 : 8'h00));
         1: add_byte($urandom_range(0, 1) ? B_TRUE : B_FALSE);
         2, 3: begin
            n = $urandom_range(0, 7);
            add_byte(B_UINT_FIRST + 8'(n));
            push_be(r, 1 << (n & 3));
         end
         4: begin
            n = $urandom_range(0, 5);
            case ($urandom_range(0, 3))
               0: add_byte(B_FIXSTR | 8'(n));
               1: begin add_byte(B_STR8); push_be(64'(n), 1); end
               2: begin add_byte(B_STR8 + 8'd1); push_be(64'(n), 2); end
               default: begin add_byte(B_STR32); push_be(64'(n), 4); end
            endcase
            repeat (n) add_byte(8'($urandom));
         end
         default: begin
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 5) == 0) n = 0;
            kind_sel = $urandom_range(0, 5);
            case (kind_sel)
               0: add_byte(B_FIXMAP | 8'(n));
               1: add_byte(B_FIXARR | 8'(n));
               2: begin add_byte(B_MAP16); push_be(64'(n), 2); end
               3: begin add_byte(B_MAP32); push_be(64'(n), 4); end
               4: begin add_byte(B_ARR16); push_be(64'(n), 2); end
               default: begin add_byte(B_ARR32); push_be(64'(n), 4); end
            endcase
            // a map holds a key and a value per entry
            is_map = (kind_sel == 0 || kind_sel == 2 || kind_sel == 3);
            repeat (is_map ? 2 * n : n) build_object(depth + 1);
         end
      endcase
   endtask

   stim_row_type rows [$];

   function automatic stim_row_type row(logic [7:0] b, logic e, logic ty = 1'b0,
                                        token_type tk = '0);
      stim_row_type r;
      r.b = b; r.eom = e; r.typed = ty; r.tok = tk;
      return r;
   endfunction

   function automatic void add_row(stim_row_type r);
      rows = {rows, r};
   endfunction

   function automatic token_type tk(logic [KIND_W-1:0] k, logic [63:0] v, logic u,
                                    logic [NEST_W-1:0] d, logic [ERR_W-1:0] e, logic dn);
      token_type t;
      t.kind = k; t.value = v; t.uns = u; t.depth = d; t.err = e; t.done = dn;
      return t;
   endfunction

   initial begin
      int sent, cut, settle;
      clear_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      add_row(row(8'h00, 1'b1, 1'b1, tk(K_INT, 64'd0, 1'b1, 5'd0, E_NONE, 1'b1)));
      add_row(row(8'h7f, 1'b1, 1'b1, tk(K_INT, 64'h7f, 1'b1, 5'd0, E_NONE, 1'b1)));
      add_row(row(8'he0, 1'b1, 1'b1,
                  tk(K_INT, 64'hffff_ffff_ffff_ffe0, 1'b0, 5'd0, E_NONE, 1'b1)));
      add_row(row(8'hff, 1'b1, 1'b1, tk(K_INT, '1, 1'b0, 5'd0, E_NONE, 1'b1)));
      add_row(row(B_TRUE, 1'b1, 1'b1, tk(K_BOOL, 64'd1, 1'b0, 5'd0, E_NONE, 1'b1)));
      add_row(row(8'hc0, 1'b1, 1'b1, tk(K_ERR, 64'd0, 1'b0, 5'd0, E_UNKNOWN, 1'b0)));
      add_row(row(8'hd3, 1'b0));
      repeat (7) add_row(row(8'hff, 1'b0));
      add_row(row(8'hff, 1'b1, 1'b1, tk(K_INT, '1, 1'b0, 5'd0, E_NONE, 1'b1)));
      add_row(row(8'hcf, 1'b0));
      repeat (7) add_row(row(8'hff, 1'b0));
      add_row(row(8'hff, 1'b1));
      add_row(row(8'h92, 1'b0));
      add_row(row(8'h00, 1'b1, 1'b1, tk(K_ERR, 64'd0, 1'b0, 5'd1, E_EARLY, 1'b0)));
      add_row(row(8'hc1, 1'b0));
      add_row(row(8'h01, 1'b1));
      add_row(row(8'h05, 1'b0));
      add_row(row(8'h06, 1'b1));
      foreach (rows[i]) send_byte(rows[i].b, rows[i].eom, rows[i].typed, rows[i].tok);

      // nesting too deep, then exactly full depth
      for (int i = 0; i < MAX_DEPTH; i++) send_byte(B_FIXARR | 8'h01, 1'b0, 1'b0, '0);
      send_byte(B_FIXARR | 8'h01, 1'b1, 1'b1,
                tk(K_ERR, 64'd0, 1'b0, NEST_W'(MAX_DEPTH), E_DEPTH, 1'b0));
      for (int i = 0; i < MAX_DEPTH; i++) send_byte(B_FIXMAP | 8'h01, 1'b0, 1'b0, '0);
      send_byte(B_FIXARR, 1'b0, 1'b0, '0);
      for (int i = 0; i < MAX_DEPTH; i++)
         send_byte(8'($urandom), i == MAX_DEPTH - 1, 1'b0, '0);

      // hold off until all tokens are back
      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(negedge clock);

      // random messages: mostly well formed, some cut short or noisy
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         msg.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
         end else begin
            build_object(0);
            if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, msg.size());
            else cut = msg.size();
            while (msg.size() > cut) void'(msg.pop_back());
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
            if ($urandom_range(0, 9) == 0) msg[$urandom_range(0, msg.size()-1)] = 8'($urandom);
         end
         foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
         sent += msg.size();
      end
      req_valid <= 1'b0;

      settle = 0;
      while (tokens_due.size() != 0) @(negedge clock);
      while (settle < 20) begin
         @(negedge clock);
         settle++;
      end
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
rtl/msgp_pkg.sv
rtl/msgp_cell.sv
rtl/msgpack_subset_tokenizer.sv
tb/msgpack_subset_tokenizer_tb.sv
